// ----- sv/ntc_pkg.sv -----
package ntc_pkg;

	localparam int LG_FRAC = 24;
	localparam int LG_INT_W = 5;
	localparam int LG_W = LG_INT_W + LG_FRAC;
	localparam int LANES = 4;
	localparam int XW = 32;

	localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;
	localparam int LN_SHIFT = 34;
	localparam int INV_T0_DEN = 5963;
	localparam int INV_T0_NUM = 20;
	localparam int C_OFFSET_K = 5453;
	localparam int C_OFFSET_SUB = 10;

	localparam int OUT_W = 13;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -13'sd4096;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 13'sd4095;

	localparam int PU_W = 20;
	localparam int NOM_W = 20;
	localparam int BETA_W = 13;
	localparam int CFG_W = 20;
	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PULLUP  = 2'd0,
		REG_NOMINAL = 2'd1,
		REG_BETA    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LOW  = 2'd1,
		ST_HIGH = 2'd2
	} status_t;

	typedef logic [XW-1:0] lane_word_t;
	typedef logic [LG_W-1:0] lg_word_t;

endpackage

// ----- sv/ntc_lg.sv -----
module ntc_lg #(
	parameter int SIDE_W = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [SIDE_W-1:0] in_side,
	input  ntc_pkg::lane_word_t [ntc_pkg::LANES-1:0] in_x,
	output logic out_valid,
	output logic [SIDE_W-1:0] out_side,
	output ntc_pkg::lg_word_t [ntc_pkg::LANES-1:0] out_lg
);

	localparam int N = ntc_pkg::LG_FRAC;
	localparam int L = ntc_pkg::LANES;
	localparam int XW = ntc_pkg::XW;
	localparam int EW = ntc_pkg::LG_INT_W;

	logic v_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];
	logic [L-1:0][EW-1:0] e_s [0:N];
	logic [L-1:0][XW-1:0] m_s [0:N];
	logic [L-1:0][N-1:0] f_s [0:N];

	logic [L-1:0][EW-1:0] e_n;
	logic [L-1:0][XW-1:0] m_n;

	// leading one sets the integer part, shift it up to Q1.31
	always_comb begin
		for (int l = 0; l < L; l++) begin
			e_n[l] = '0;
			for (int b = 0; b < XW; b++) begin
				if (in_x[l][b]) e_n[l] = EW'(b);
			end
			m_n[l] = in_x[l] << (EW'(XW - 1) - e_n[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			e_s[0] <= e_n;
			m_s[0] <= m_n;
			f_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_sq
		logic [L-1:0][XW-1:0] m_nx;
		logic [L-1:0][N-1:0] f_nx;

		always_comb begin
			logic [2*XW-1:0] sq;
			logic [XW:0] t;
			for (int l = 0; l < L; l++) begin
				sq = (2*XW)'(m_s[g][l]) * (2*XW)'(m_s[g][l]);
				t = sq[2*XW-1:XW-1];
				m_nx[l] = t[XW] ? t[XW:1] : t[XW-1:0];
				f_nx[l] = {f_s[g][l][N-2:0], t[XW]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				e_s[g+1] <= e_s[g];
				m_s[g+1] <= m_nx;
				f_s[g+1] <= f_nx;
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_side = side_s[N];

	always_comb begin
		for (int l = 0; l < L; l++) begin
			out_lg[l] = {e_s[N][l], f_s[N][l]};
		end
	end

endmodule

// ----- sv/ntc_thermistor_to_celsius_unit.sv -----
// NTC thermistor divider reading to degrees Celsius (beta equation).
// Input stream s_*: one ADC code per request in s_tdata. Output stream m_*:
// temperature (units of 2^-FRAC_BITS degree, plus half a degree) and a
// status code (ok, saturated low, saturated high).
// The cfg port writes pull-up ohms, nominal ohms at 25 C and beta; write
// only while no request is in flight. Registers are sampled when a code
// is accepted.
// From acceptance to m_tvalid a request passes the four log2 lanes
// (one normalize stage plus one squaring multiplier per fraction
// bit), the scaling multipliers, the restoring divider (one
// quotient bit per stage) and the output register. Throughput
// is one request per cycle while the receiver does not stall. When
// the receiver stalls the whole pipeline holds; s_tready drops while
// the output register is full and not taken. Reset empties the pipeline
// and loads the registers with 10000 ohm, 10000 ohm and beta 3950.
module ntc_thermistor_to_celsius_unit #(
	parameter int ADC_BITS = 12,
	parameter int FRAC_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0] s_tdata, // adc_code
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata, // temperature, status
	input  logic cfg_we,
	input  logic [ntc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ntc_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int BW = ntc_pkg::BETA_W;
	localparam int SIDE_W = BW + 1;
	localparam int S_W = ntc_pkg::LG_W + 2;
	localparam int PROD_W = 2 * S_W;
	localparam int P_W = PROD_W - ntc_pkg::LN_SHIFT;
	localparam int E_W = 42;
	localparam int D_W = E_W + 5;
	localparam int NUM_W = 58 + FRAC_BITS;
	localparam int QW = ntc_pkg::OUT_W;
	localparam int C_VAL = ntc_pkg::C_OFFSET_K * (2 ** FRAC_BITS) - ntc_pkg::C_OFFSET_SUB;
	localparam int BK_MUL = ntc_pkg::INV_T0_NUM * ntc_pkg::INV_T0_DEN;
	localparam int BK_SH = 20 + FRAC_BITS;

	logic [ntc_pkg::PU_W-1:0] pullup_q;
	logic [ntc_pkg::NOM_W-1:0] nominal_q;
	logic [BW-1:0] beta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pullup_q <= 20'd10000;
			nominal_q <= 20'd10000;
			beta_q <= 13'd3950;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ntc_pkg::REG_PULLUP:  pullup_q <= cfg_wdata[ntc_pkg::PU_W-1:0];
				ntc_pkg::REG_NOMINAL: nominal_q <= cfg_wdata[ntc_pkg::NOM_W-1:0];
				ntc_pkg::REG_BETA:    beta_q <= cfg_wdata[BW-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic valid_q;
	logic signed [QW-1:0] temp_q;
	ntc_pkg::status_t status_q;

	assign en = !valid_q || m_tready;
	assign s_tready = en;

	logic [ADC_BITS-1:0] code;
	logic bad_in;
	ntc_pkg::lane_word_t [ntc_pkg::LANES-1:0] lg_x;

	assign code = s_tdata[ADC_BITS-1:0];
	assign bad_in = (code == '0) || (pullup_q == '0) || (nominal_q == '0) || (beta_q == '0);

	always_comb begin
		lg_x[0] = ntc_pkg::XW'(code);
		lg_x[1] = ntc_pkg::XW'(pullup_q);
		lg_x[2] = (ntc_pkg::XW'(1) << ADC_BITS) - ntc_pkg::XW'(code);
		lg_x[3] = ntc_pkg::XW'(nominal_q);
	end

	logic lg_valid;
	logic [SIDE_W-1:0] lg_side;
	ntc_pkg::lg_word_t [ntc_pkg::LANES-1:0] lg_out;

	ntc_lg #(.SIDE_W(SIDE_W)) u_lg (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_tvalid),
		.in_side({bad_in, beta_q}),
		.in_x(lg_x),
		.out_valid(lg_valid),
		.out_side(lg_side),
		.out_lg(lg_out)
	);

	// stage 1: log ratio sum
	logic v_s1, bad_s1;
	logic [BW-1:0] beta_s1;
	logic signed [S_W-1:0] s_s1;

	// stage 2: scale to natural log
	logic v_s2, bad_s2;
	logic [BW-1:0] beta_s2;
	logic signed [PROD_W-1:0] prod_s2;

	// stage 3: truncate toward zero
	logic v_s3, bad_s3;
	logic [BW-1:0] beta_s3;
	logic signed [P_W-1:0] p_s3;

	// stage 4: denominator E and beta term of numerator
	logic v_s4, bad_s4;
	logic signed [E_W-1:0] e_s4;
	logic signed [NUM_W-1:0] bk_s4;

	// stage 5: numerator and divisor
	logic v_s5, bad_s5;
	logic signed [NUM_W-1:0] num_s5;
	logic [D_W-1:0] d_s5;

	// stage 6: range check, offset numerator into the quotient window
	logic v_s6, low_s6, high_s6;
	logic signed [NUM_W-1:0] r_s6;
	logic [D_W-1:0] d_s6;

	logic signed [PROD_W-1:0] prod_bias;
	logic signed [E_W-1:0] e_next;
	logic signed [NUM_W-1:0] dk;

	assign prod_bias = prod_s2 + (prod_s2[PROD_W-1] ?
		PROD_W'((64'd1 << ntc_pkg::LN_SHIFT) - 64'd1) : PROD_W'(0));
	assign e_next = $signed((E_W'(beta_s3) * E_W'(ntc_pkg::INV_T0_NUM)) << 20)
		+ E_W'(p_s3) * E_W'(ntc_pkg::INV_T0_DEN);
	assign dk = $signed(NUM_W'(d_s5) << (QW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= lg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= lg_side[SIDE_W-1];
			beta_s1 <= lg_side[BW-1:0];
			s_s1 <= S_W'(lg_out[0]) + S_W'(lg_out[1]) - S_W'(lg_out[2]) - S_W'(lg_out[3]);

			bad_s2 <= bad_s1;
			beta_s2 <= beta_s1;
			prod_s2 <= PROD_W'(s_s1) * PROD_W'(ntc_pkg::LN2_Q30);

			bad_s3 <= bad_s2;
			beta_s3 <= beta_s2;
			p_s3 <= prod_bias[PROD_W-1:ntc_pkg::LN_SHIFT];

			bad_s4 <= bad_s3;
			e_s4 <= e_next;
			bk_s4 <= $signed((NUM_W'(beta_s3) * NUM_W'(BK_MUL)) << BK_SH);

			bad_s5 <= bad_s4 || (e_s4 <= 0);
			num_s5 <= bk_s4 - NUM_W'(e_s4) * NUM_W'(C_VAL);
			d_s5 <= D_W'(e_s4[E_W-2:0]) * D_W'(ntc_pkg::INV_T0_NUM);

			low_s6 <= bad_s5 || (num_s5 < -dk);
			high_s6 <= num_s5 >= dk;
			r_s6 <= num_s5 + dk;
			d_s6 <= d_s5;
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	logic v_d [0:QW];
	logic low_d [0:QW];
	logic high_d [0:QW];
	logic signed [NUM_W-1:0] r_d [0:QW];
	logic [D_W-1:0] d_d [0:QW];
	logic [QW-1:0] q_d [0:QW];

	assign v_d[0] = v_s6;
	assign low_d[0] = low_s6;
	assign high_d[0] = high_s6;
	assign r_d[0] = r_s6;
	assign d_d[0] = d_s6;
	assign q_d[0] = '0;

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic signed [NUM_W-1:0] dsh;
		logic ge;

		assign dsh = $signed(NUM_W'(d_d[j]) << K);
		assign ge = r_d[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j+1] <= 1'b0;
			end else if (en) begin
				v_d[j+1] <= v_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				low_d[j+1] <= low_d[j];
				high_d[j+1] <= high_d[j];
				d_d[j+1] <= d_d[j];
				r_d[j+1] <= ge ? r_d[j] - dsh : r_d[j];
				q_d[j+1] <= q_d[j] | (ge ? (QW'(1) << K) : QW'(0));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_d[QW];
		end
	end

	// quotient is offset by the bottom of the range
	always_ff @(posedge clk) begin
		if (en) begin
			if (low_d[QW]) begin
				temp_q <= ntc_pkg::OUT_MIN;
				status_q <= ntc_pkg::ST_LOW;
			end else if (high_d[QW]) begin
				temp_q <= ntc_pkg::OUT_MAX;
				status_q <= ntc_pkg::ST_HIGH;
			end else begin
				temp_q <= $signed(q_d[QW] - QW'(1 << (QW - 1)));
				status_q <= ntc_pkg::ST_OK;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, status_q, temp_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == ntc_pkg::ST_LOW |-> temp_q == ntc_pkg::OUT_MIN)
		else $error("low saturation without minimum temperature");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q == ntc_pkg::ST_HIGH |-> temp_q == ntc_pkg::OUT_MAX)
		else $error("high saturation without maximum temperature");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_d[QW] && en |=> valid_q)
		else $error("divider result dropped before output register");

endmodule
